@@ design/assert_macros.svh @@
// Assertion macros shared by the UTF-8 stream validator modules.
// Each macro expects signals named clk and rst_n in the module that uses it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/utf8v_pkg.sv @@
// Package for the UTF-8 stream validator: payload structs, automaton state codes
// and the byte-to-transition-word lookup. No dependencies.
package utf8v_pkg;

  // Input transaction payload.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
    logic       last_byte;
  } in_t;

  // Result transaction payload.
  typedef struct packed {
    logic        error_seen;
    logic        mid_sequence;
    logic        string_done;
    logic [31:0] accepted_length;
  } out_t;

  typedef logic [4:0]  dfa_state_t;
  typedef logic [31:0] trans_word_t;

  // Automaton states; each code is also the bit offset of its field in a
  // transition word.
  localparam dfa_state_t ST_ERROR    = 5'd0;
  localparam dfa_state_t ST_NEED2    = 5'd1;
  localparam dfa_state_t ST_NEED3    = 5'd5;
  localparam dfa_state_t ST_AFTER_E0 = 5'd6;
  localparam dfa_state_t ST_BEGIN    = 5'd11;
  localparam dfa_state_t ST_NEED1    = 5'd16;
  localparam dfa_state_t ST_AFTER_ED = 5'd20;
  localparam dfa_state_t ST_AFTER_F0 = 5'd25;
  localparam dfa_state_t ST_AFTER_F4 = 5'd30;

  localparam int unsigned STATE_BITS = 5;

  // Transition words for the continuation-byte classes.
  localparam trans_word_t CONT_COMMON = (32'(ST_BEGIN) << ST_NEED1)
                                      | (32'(ST_NEED1) << ST_NEED2)
                                      | (32'(ST_NEED2) << ST_NEED3);
  localparam trans_word_t CONT_80_8F = CONT_COMMON | (32'(ST_NEED1) << ST_AFTER_ED)
                                     | (32'(ST_NEED2) << ST_AFTER_F4);
  localparam trans_word_t CONT_90_9F = CONT_COMMON | (32'(ST_NEED1) << ST_AFTER_ED)
                                     | (32'(ST_NEED2) << ST_AFTER_F0);
  localparam trans_word_t CONT_A0_BF = CONT_COMMON | (32'(ST_NEED1) << ST_AFTER_E0)
                                     | (32'(ST_NEED2) << ST_AFTER_F0);

  // Packed transition word selected by one byte value.
  function automatic trans_word_t trans_word(input logic [7:0] b);
    trans_word_t w;
    w = '0;
    case (b) inside
      [8'h01:8'h7F]:               w = 32'(ST_BEGIN) << ST_BEGIN;
      [8'h80:8'h8F]:               w = CONT_80_8F;
      [8'h90:8'h9F]:               w = CONT_90_9F;
      [8'hA0:8'hBF]:               w = CONT_A0_BF;
      [8'hC2:8'hDF]:               w = 32'(ST_NEED1) << ST_BEGIN;
      8'hE0:                       w = 32'(ST_AFTER_E0) << ST_BEGIN;
      8'hED:                       w = 32'(ST_AFTER_ED) << ST_BEGIN;
      [8'hE1:8'hEC], [8'hEE:8'hEF]: w = 32'(ST_NEED2) << ST_BEGIN;
      8'hF0:                       w = 32'(ST_AFTER_F0) << ST_BEGIN;
      [8'hF1:8'hF3]:               w = 32'(ST_NEED3) << ST_BEGIN;
      8'hF4:                       w = 32'(ST_AFTER_F4) << ST_BEGIN;
      // NUL, C0/C1 leads and F5..FF all go to the error state.
      default:                     w = '0;
    endcase
    return w;
  endfunction

endpackage

@@ design/utf8v_in_reg.sv @@
// Input register of the UTF-8 stream validator: holds one accepted byte
// transaction until the step logic consumes it. Depends on utf8v_pkg.
module utf8v_in_reg (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  utf8v_pkg::in_t in_data,
  output logic           item_valid,
  output utf8v_pkg::in_t item,
  input  logic           item_taken
);
  import utf8v_pkg::*;

  logic item_valid_r, item_valid_nxt;
  in_t  item_r, item_nxt;

  // Space is free when the register is empty or its item leaves this cycle.
  assign in_ready = !item_valid_r || item_taken;

  always_comb begin
    item_valid_nxt = item_valid_r;
    item_nxt       = item_r;
    if (item_taken) begin
      item_valid_nxt = 1'b0;
    end
    if (in_valid && in_ready) begin
      item_valid_nxt = 1'b1;
      item_nxt       = in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else begin
      item_valid_r <= item_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
  end

  assign item_valid = item_valid_r;
  assign item       = item_r;

endmodule

@@ design/utf8v_step.sv @@
// Automaton step of the UTF-8 stream validator: holds the DFA state and byte
// count and forms one result per byte. Depends on utf8v_pkg and assert_macros.svh.
`include "assert_macros.svh"

module utf8v_step #(
  parameter int unsigned COUNT_BITS = 32
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            item_valid,
  input  utf8v_pkg::in_t  item,
  output logic            item_taken,
  output logic            res_valid,
  output utf8v_pkg::out_t res,
  input  logic            res_ready
);
  import utf8v_pkg::*;

  dfa_state_t            dfa_state_r, dfa_state_nxt;
  logic [COUNT_BITS-1:0] byte_count_r, byte_count_nxt;

  dfa_state_t            state_base;
  logic [COUNT_BITS-1:0] count_base;
  trans_word_t           word;
  trans_word_t           shifted;
  logic                  err;
  logic [31:0]           len_sat;

  assign res_valid  = item_valid;
  assign item_taken = item_valid && res_ready;

  // A first byte restarts the automaton and the count before it is processed.
  assign state_base = item.first_byte ? ST_BEGIN : dfa_state_r;
  assign count_base = item.first_byte ? '0 : byte_count_r;

  // Table lookup, then the field at the current state's offset is the next state.
  assign word          = trans_word(item.data_byte);
  assign shifted       = word >> state_base;
  assign dfa_state_nxt = shifted[STATE_BITS-1:0];

  // Saturating byte counter.
  assign byte_count_nxt = (&count_base) ? count_base : count_base + COUNT_BITS'(1);

  // Clamp the count to the 32-bit length field.
  generate
    if (COUNT_BITS > 32) begin : g_wide_count
      assign len_sat = (|byte_count_nxt[COUNT_BITS-1:32]) ? '1 : byte_count_nxt[31:0];
    end else begin : g_narrow_count
      assign len_sat = 32'(byte_count_nxt);
    end
  endgenerate

  // Result fields for this byte.
  assign err = (dfa_state_nxt == ST_ERROR);
  always_comb begin
    res.error_seen      = err;
    res.mid_sequence    = !err && (dfa_state_nxt != ST_BEGIN);
    res.string_done     = item.last_byte;
    res.accepted_length = (item.last_byte && !err) ? len_sat : '0;
  end

  // State advances only when the result transaction is passed on.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dfa_state_r  <= ST_BEGIN;
      byte_count_r <= '0;
    end else if (item_taken) begin
      dfa_state_r  <= dfa_state_nxt;
      byte_count_r <= byte_count_nxt;
    end
  end

  // The error state is left only through a first byte.
  `ASSERT_NEXT(a_error_absorbing, dfa_state_r == ST_ERROR && !(item_taken && item.first_byte), dfa_state_r == ST_ERROR, "error state left without a first byte")
  // A first byte leaves a count of one.
  `ASSERT_NEXT(a_first_count, item_taken && item.first_byte, byte_count_r == COUNT_BITS'(1), "count not restarted by first byte")

endmodule

@@ design/utf8v_out_reg.sv @@
// Result register of the UTF-8 stream validator: holds one result transaction
// until the consumer takes it. Depends on utf8v_pkg and assert_macros.svh.
`include "assert_macros.svh"

module utf8v_out_reg (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            res_valid,
  output logic            res_ready,
  input  utf8v_pkg::out_t res,
  output logic            out_valid,
  input  logic            out_ready,
  output utf8v_pkg::out_t out_data
);
  import utf8v_pkg::*;

  logic out_valid_r, out_valid_nxt;
  out_t out_data_r, out_data_nxt;

  // The register takes a new result when empty or when its result leaves now.
  assign res_ready = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // A length is reported only on a clean last byte.
  `ASSERT_SAME(a_len_clean, out_valid_r && out_data_r.accepted_length != '0, out_data_r.string_done && !out_data_r.error_seen, "length reported on non-final or failed byte")
  // Error and mid-sequence are exclusive.
  `ASSERT_SAME(a_err_mid_excl, out_valid_r, !(out_data_r.error_seen && out_data_r.mid_sequence), "error and mid-sequence both set")

endmodule

@@ design/utf8_stream_validator_top.sv @@
// UTF-8 stream validator: one byte per transaction, one result per byte, one
// transaction per clock cycle sustained while results are taken; an accepted byte
// is loaded into the input register, and its result is then loaded into the result
// register through the table lookup and shift that update the automaton state.
// Backpressure on the result side stalls the input side. The count width is set by
// COUNT_BITS; the reported length saturates at all ones. Depends on utf8v_pkg and
// the utf8v_* modules.
module utf8_stream_validator_top #(
  parameter int unsigned COUNT_BITS = 32
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  utf8v_pkg::in_t  in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output utf8v_pkg::out_t out_data
);
  import utf8v_pkg::*;

  logic item_valid;
  in_t  item;
  logic item_taken;
  logic res_valid;
  logic res_ready;
  out_t res;

  // Input register.
  utf8v_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .item_valid (item_valid),
    .item       (item),
    .item_taken (item_taken)
  );

  // Automaton state, byte count and result formation.
  utf8v_step #(
    .COUNT_BITS (COUNT_BITS)
  ) u_step (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .item       (item),
    .item_taken (item_taken),
    .res_valid  (res_valid),
    .res        (res),
    .res_ready  (res_ready)
  );

  // Result register.
  utf8v_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

@@ tb/sv/tb.sv @@
// Self-checking testbench for the UTF-8 stream validator: directed strings, random
// traffic under three idle mixes and a long result-side stall, all checked against
// an in-bench automaton model. Depends on utf8v_pkg and utf8_stream_validator_top.
module tb;
  import utf8v_pkg::*;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_t  in_data;
  logic out_valid;
  logic out_ready;
  out_t out_data;

  utf8_stream_validator_top #(.COUNT_BITS(32)) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // Model of the validator state and the results it still owes.
  dfa_state_t  model_state;
  logic [31:0] model_count;
  out_t        pending_results[$];
  logic [7:0]  str_bytes[$];

  // Traffic shaping and run statistics.
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned mismatches;
  int unsigned results_seen;
  int unsigned bytes_sent;
  int unsigned strings_checked;
  int unsigned error_strings;
  int unsigned stall_cycles;
  int unsigned stall_len;
  bit          stall_toggle;
  bit          stall_seen;
  int unsigned stall_left;

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run guard: ends a hung simulation.
  initial begin
    #3000000;
    $display("Timeout with %0d results still outstanding", pending_results.size());
    $display("*** FAILED ***");
    $finish;
  end

  // Next automaton state for one byte, written state by state.
  function automatic dfa_state_t utf8_next_state(input dfa_state_t s, input logic [7:0] b);
    logic       cont;
    dfa_state_t n;
    cont = (b[7:6] == 2'b10);
    n = ST_ERROR;
    case (s)
      ST_BEGIN: begin
        if (b >= 8'h01 && b <= 8'h7F) n = ST_BEGIN;
        else if (b >= 8'hC2 && b <= 8'hDF) n = ST_NEED1;
        else if (b == 8'hE0) n = ST_AFTER_E0;
        else if (b == 8'hED) n = ST_AFTER_ED;
        else if (b >= 8'hE1 && b <= 8'hEF) n = ST_NEED2;
        else if (b == 8'hF0) n = ST_AFTER_F0;
        else if (b >= 8'hF1 && b <= 8'hF3) n = ST_NEED3;
        else if (b == 8'hF4) n = ST_AFTER_F4;
      end
      ST_NEED1:    if (cont) n = ST_BEGIN;
      ST_NEED2:    if (cont) n = ST_NEED1;
      ST_NEED3:    if (cont) n = ST_NEED2;
      ST_AFTER_E0: if (b >= 8'hA0 && b <= 8'hBF) n = ST_NEED1;
      ST_AFTER_ED: if (b >= 8'h80 && b <= 8'h9F) n = ST_NEED1;
      ST_AFTER_F0: if (b >= 8'h90 && b <= 8'hBF) n = ST_NEED2;
      ST_AFTER_F4: if (b >= 8'h80 && b <= 8'h8F) n = ST_NEED2;
      default:     n = ST_ERROR;
    endcase
    return n;
  endfunction

  // Advance the model by one accepted byte and queue the result it produces.
  task automatic predict_byte(input in_t item);
    out_t r;
    if (item.first_byte) begin
      model_state = ST_BEGIN;
      model_count = '0;
    end
    model_state = utf8_next_state(model_state, item.data_byte);
    // The count saturates; a 32-bit wrap is far beyond any run length here.
    if (model_count != '1) model_count++;
    r.error_seen      = (model_state == ST_ERROR);
    r.mid_sequence    = !r.error_seen && (model_state != ST_BEGIN);
    r.string_done     = item.last_byte;
    r.accepted_length = (item.last_byte && !r.error_seen) ? model_count : 32'd0;
    pending_results.push_back(r);
  endtask

  // Offer one byte transaction, with an optional idle gap first, and wait for it.
  task automatic send_byte(input logic [7:0] b, input logic f, input logic l);
    in_t item;
    item.data_byte  = b;
    item.first_byte = f;
    item.last_byte  = l;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    predict_byte(item);
    bytes_sent++;
  endtask

  // Send the bytes in str_bytes as one framed string.
  task automatic send_string();
    int n;
    n = str_bytes.size();
    for (int i = 0; i < n; i++) begin
      send_byte(str_bytes[i], i == 0, i == n - 1);
    end
  endtask

  // Fill str_bytes with n_chars random, well-formed code points, favoring range edges.
  task automatic build_valid_string(input int unsigned n_chars);
    int unsigned cp;
    str_bytes.delete();
    for (int unsigned c = 0; c < n_chars; c++) begin
      if ($urandom_range(7) == 0) begin
        case ($urandom_range(9))
          0: cp = 32'h01;
          1: cp = 32'h7F;
          2: cp = 32'h80;
          3: cp = 32'h7FF;
          4: cp = 32'h800;
          5: cp = 32'hD7FF;
          6: cp = 32'hE000;
          7: cp = 32'hFFFF;
          8: cp = 32'h10000;
          default: cp = 32'h10FFFF;
        endcase
      end else begin
        case ($urandom_range(3))
          0: cp = $urandom_range(32'h7F, 32'h01);
          1: cp = $urandom_range(32'h7FF, 32'h80);
          2: begin
            cp = $urandom_range(32'hFFFF, 32'h800);
            // Step out of the surrogate range.
            if (cp >= 32'hD800 && cp <= 32'hDFFF) cp = cp - 32'h800;
          end
          default: cp = $urandom_range(32'h10FFFF, 32'h10000);
        endcase
      end
      // Encode the code point.
      if (cp < 32'h80) begin
        str_bytes.push_back(8'(cp));
      end else if (cp < 32'h800) begin
        str_bytes.push_back(8'(32'hC0 | (cp >> 6)));
        str_bytes.push_back(8'(32'h80 | (cp & 32'h3F)));
      end else if (cp < 32'h10000) begin
        str_bytes.push_back(8'(32'hE0 | (cp >> 12)));
        str_bytes.push_back(8'(32'h80 | ((cp >> 6) & 32'h3F)));
        str_bytes.push_back(8'(32'h80 | (cp & 32'h3F)));
      end else begin
        str_bytes.push_back(8'(32'hF0 | (cp >> 18)));
        str_bytes.push_back(8'(32'h80 | ((cp >> 12) & 32'h3F)));
        str_bytes.push_back(8'(32'h80 | ((cp >> 6) & 32'h3F)));
        str_bytes.push_back(8'(32'h80 | (cp & 32'h3F)));
      end
    end
  endtask

  // Let every owed result arrive, then a few more cycles for the pipeline.
  task automatic wait_drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Directed strings: byte-range edges, rejection rules and the framing corners.
  task automatic test_directed_cases();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    // Single-byte strings with first and last together: highest ASCII, NUL, top byte.
    send_byte(8'h7F, 1'b1, 1'b1);
    send_byte(8'h00, 1'b1, 1'b1);
    send_byte(8'hFF, 1'b1, 1'b1);
    // C0 lead and a lead above F4.
    send_byte(8'hC0, 1'b1, 1'b1);
    send_byte(8'hF5, 1'b1, 1'b1);
    // Highest two-byte form and the lowest three-byte form.
    str_bytes = '{8'hDF, 8'hBF};
    send_string();
    str_bytes = '{8'hE0, 8'hA0, 8'h80};
    send_string();
    // Overlong three-byte form.
    str_bytes = '{8'hE0, 8'h9F};
    send_string();
    // Surrogate half.
    str_bytes = '{8'hED, 8'hA0};
    send_string();
    // Highest legal code point, then one just past it.
    str_bytes = '{8'hF4, 8'h8F, 8'hBF, 8'hBF};
    send_string();
    str_bytes = '{8'hF4, 8'h90};
    send_string();
    // Incomplete tail: the length is still reported with mid-sequence set.
    str_bytes = '{8'hF0, 8'h90};
    send_string();
    // A byte after the last one carries on with the same state and count.
    send_byte(8'h80, 1'b0, 1'b1);
    // Stray continuation byte and a C1 lead in the middle of ASCII.
    send_byte(8'h80, 1'b1, 1'b1);
    str_bytes = '{8'h41, 8'hC1, 8'h42};
    send_string();
    wait_drain();
  endtask

  // Random traffic: mostly framed strings, some corrupted, plus unframed noise.
  task automatic test_random_traffic(input int unsigned n_items, input int unsigned s_pct,
                                     input int unsigned r_pct);
    int unsigned start;
    int unsigned pos;
    int unsigned n_noise;
    logic [7:0]  bad;
    start = bytes_sent;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    while (bytes_sent - start < n_items) begin
      if ($urandom_range(99) < 85) begin
        build_valid_string($urandom_range(3) == 0 ? $urandom_range(12, 1)
                                                   : $urandom_range(4, 1));
        // A quarter of the strings get one defect.
        if ($urandom_range(3) == 0) begin
          pos = $urandom_range(str_bytes.size() - 1);
          case ($urandom_range(7))
            0: str_bytes[pos] = 8'($urandom);
            1: if (str_bytes.size() > 1) void'(str_bytes.pop_back());
            2: str_bytes.push_back(8'($urandom_range(8'hBF, 8'h80)));
            3: begin
              case ($urandom_range(2))
                0: bad = 8'h00;
                1: bad = 8'($urandom_range(8'hC1, 8'hC0));
                default: bad = 8'($urandom_range(8'hFF, 8'hF5));
              endcase
              str_bytes.insert(pos, bad);
            end
            4: begin
              str_bytes.insert(pos, 8'($urandom_range(8'hBF, 8'h80)));
              str_bytes.insert(pos, 8'($urandom_range(8'hBF, 8'hA0)));
              str_bytes.insert(pos, 8'hED);
            end
            5: begin
              str_bytes.insert(pos, 8'($urandom_range(8'hBF, 8'h80)));
              str_bytes.insert(pos, 8'($urandom_range(8'h9F, 8'h80)));
              str_bytes.insert(pos, 8'hE0);
            end
            6: begin
              str_bytes.insert(pos, 8'($urandom_range(8'hBF, 8'h80)));
              str_bytes.insert(pos, 8'($urandom_range(8'hBF, 8'h90)));
              str_bytes.insert(pos, 8'hF4);
            end
            default: begin
              str_bytes.insert(pos, 8'($urandom_range(8'hBF, 8'h80)));
              str_bytes.insert(pos, 8'($urandom_range(8'h8F, 8'h80)));
              str_bytes.insert(pos, 8'hF0);
            end
          endcase
        end
        send_string();
      end else begin
        // Noise: random bytes with random framing flags.
        n_noise = $urandom_range(8, 1);
        for (int unsigned i = 0; i < n_noise; i++) begin
          send_byte(8'($urandom), $urandom_range(3) == 0, $urandom_range(3) == 0);
        end
      end
    end
    wait_drain();
  endtask

  // Hold the result side off for a long stretch while bytes keep coming.
  task automatic test_output_stall();
    int unsigned start;
    start = bytes_sent;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    stall_len = 200;
    stall_toggle = ~stall_toggle;
    while (bytes_sent - start < 60) begin
      build_valid_string($urandom_range(5, 1));
      send_string();
    end
    wait_drain();
  endtask

  // Result side: check each result transaction and drive ready for the next edge.
  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Result with nothing outstanding: %p", out_data);
      end else begin
        want = pending_results.pop_front();
        if (out_data !== want) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("Mismatch at result %0d: expected err=%0b mid=%0b done=%0b len=%0d",
                     results_seen, want.error_seen, want.mid_sequence, want.string_done,
                     want.accepted_length);
            $display("  actual err=%0b mid=%0b done=%0b len=%0d", out_data.error_seen,
                     out_data.mid_sequence, out_data.string_done, out_data.accepted_length);
          end
        end
        if (want.string_done) begin
          strings_checked++;
          if (want.error_seen) error_strings++;
        end
      end
    end
    // A new stall request loads the hold-off counter.
    if (stall_toggle != stall_seen) begin
      stall_seen = stall_toggle;
      stall_left = stall_len;
    end
    if (stall_left > 0) begin
      stall_left--;
      if (in_valid && !in_ready) stall_cycles++;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Test sequence.
  initial begin
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_data         = '0;
    out_ready       = 1'b0;
    send_idle_pct   = 0;
    recv_idle_pct   = 0;
    mismatches      = 0;
    results_seen    = 0;
    bytes_sent      = 0;
    strings_checked = 0;
    error_strings   = 0;
    stall_cycles    = 0;
    stall_len       = 0;
    stall_toggle    = 1'b0;
    stall_seen      = 1'b0;
    stall_left      = 0;
    model_state     = ST_BEGIN;
    model_count     = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_cases();
    test_random_traffic(230, 10, 83);
    test_random_traffic(230, 83, 10);
    test_random_traffic(200, 0, 0);
    test_output_stall();

    $display("Checked %0d byte results, %0d framed string ends (%0d rejected).",
             results_seen, strings_checked, error_strings);
    $display("Input was held off for %0d cycles during the long output stall.",
             stall_cycles);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

@@ utf8_stream_validator_top.f @@
+incdir+design
design/utf8v_pkg.sv
design/utf8v_in_reg.sv
design/utf8v_step.sv
design/utf8v_out_reg.sv
design/utf8_stream_validator_top.sv
tb/sv/tb.sv
